[rtl/msbr_pkg.sv]
// ----------------------------------------------------------------------------
// msbr_pkg
// Shared constants and a helper for the MSB-first bit reader with ns decode.
// ----------------------------------------------------------------------------
package msbr_pkg;

  localparam int MSBR_MAX_BYTES = 256;
  localparam int BYTE_W         = 8;
  localparam int OPERAND_W      = 16;
  localparam int VALUE_W        = 32;
  localparam int MAX_READ_BITS  = 32;
  localparam int CNT_W          = 6;
  localparam int BITLEN_W       = 5;

  typedef enum logic [1:0] {
    CMD_LOAD      = 2'd0,
    CMD_READ_BITS = 2'd1,
    CMD_READ_NS   = 2'd2,
    CMD_RESTART   = 2'd3
  } cmd_t;

  // number of significant bits in a 16 bit operand
  function automatic logic [BITLEN_W-1:0] bit_length(input logic [OPERAND_W-1:0] x);
    logic [BITLEN_W-1:0] len;
    len = '0;
    for (int i = 0; i < OPERAND_W; i++) begin
      if (x[i]) begin
        len = BITLEN_W'(i + 1);
      end
    end
    return len;
  endfunction

endpackage

[rtl/msb_bit_reader_with_ns_decode_unit.sv]
// ----------------------------------------------------------------------------
// msb_bit_reader_with_ns_decode_unit
// MSB-first bit reader over a loaded byte buffer, with ns value decoding.
//
// Input channel (in_valid/in_ready) carries cmd, byte_in and operand_n.
// Load and restart beats produce no result; read-bits and read-ns beats
// produce one result beat (value, status) on out_valid/out_ready.
// Bits are taken one per cycle from the byte buffer, which has one write
// port and one read port with registered read; the read address runs one
// bit ahead. Load and restart complete at acceptance. A read of n bits
// shifts in its n bits and then enters the output step; read-ns takes w - 1
// bit steps, a check, an extra bit and a correction when needed, and the
// output step. Failing checks at acceptance go straight to the output
// step. One item is worked on at a time: a new beat is accepted only while
// the unit is idle.
// The result sits in an output register: a new item is accepted while it
// waits, but the next result holds in its final step until out_ready frees
// the register. Reset clears position, byte count and the output valid; the
// buffer contents are not cleared and only loaded bytes are ever read.
// ----------------------------------------------------------------------------
module msb_bit_reader_with_ns_decode_unit
  import msbr_pkg::*;
#(
  parameter int MAX_BYTES = MSBR_MAX_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           cmd,
  input  logic [BYTE_W-1:0]    byte_in,
  input  logic [OPERAND_W-1:0] operand_n,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VALUE_W-1:0]   value,
  output logic                 status
);

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int PW = $clog2(MAX_BYTES * 8 + 1);
  localparam int SW = ((PW > OPERAND_W) ? PW : OPERAND_W) + 2;
  localparam int MW = OPERAND_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_NS_CHECK,
    ST_NS_EXTRA,
    ST_NS_FIX,
    ST_DONE
  } state_t;

  state_t            state;
  logic [PW-1:0]     bit_position;
  logic [CW-1:0]     byte_count;
  logic [PW-1:0]     p;
  logic [CNT_W-1:0]  cnt;
  logic [VALUE_W-1:0] acc;
  logic [MW-1:0]     m;
  logic              is_ns;
  logic              ok;

  logic              accept;
  logic [SW-1:0]     limit;
  logic [SW-1:0]     rb_end;
  logic [SW-1:0]     ns_end;
  logic [BITLEN_W-1:0] w;
  logic [BITLEN_W-1:0] wm1;
  logic [MW-1:0]     m_calc;
  logic [PW-1:0]     p_inc;
  logic [PW-1:0]     addr_pos;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              cur_bit;
  logic              wr_en;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign limit  = SW'({byte_count, 3'b000});
  assign rb_end = SW'(bit_position) + SW'(operand_n);
  assign w      = bit_length(operand_n);
  assign wm1    = w - 1'b1;
  assign ns_end = SW'(bit_position) + SW'(wm1);
  assign m_calc = (MW'(1) << w) - MW'(operand_n);

  // read address tracks the byte of the next bit to be consumed
  assign p_inc = p + 1'b1;
  always_comb begin
    case (state)
      ST_IDLE:  addr_pos = bit_position;
      ST_SHIFT: addr_pos = p_inc;
      default:  addr_pos = p;
    endcase
  end
  assign rd_addr = AW'(addr_pos >> 3);
  assign cur_bit = rd_data[3'd7 - p[2:0]];

  assign wr_en = accept && (cmd == CMD_LOAD) && (byte_count < CW'(MAX_BYTES));

  msbr_store #(
    .MAX_BYTES(MAX_BYTES),
    .AW       (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(AW'(byte_count)),
    .wr_data(byte_in),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      bit_position <= '0;
      byte_count   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            p     <= bit_position;
            acc   <= '0;
            m     <= m_calc;
            is_ns <= 1'b0;
            ok    <= 1'b0;
            case (cmd)
              CMD_LOAD: begin
                if (wr_en) begin
                  byte_count <= byte_count + 1'b1;
                end
              end
              CMD_RESTART: begin
                bit_position <= '0;
                byte_count   <= '0;
              end
              CMD_READ_BITS: begin
                if (operand_n <= OPERAND_W'(MAX_READ_BITS) && rb_end <= limit) begin
                  cnt <= CNT_W'(operand_n);
                  if (operand_n == '0) begin
                    ok    <= 1'b1;
                    state <= ST_DONE;
                  end else begin
                    state <= ST_SHIFT;
                  end
                end else begin
                  state <= ST_DONE;
                end
              end
              default: begin
                // read ns
                is_ns <= 1'b1;
                cnt   <= CNT_W'(wm1);
                if (operand_n != '0 && ns_end <= limit) begin
                  if (wm1 == '0) begin
                    state <= ST_NS_CHECK;
                  end else begin
                    state <= ST_SHIFT;
                  end
                end else begin
                  state <= ST_DONE;
                end
              end
            endcase
          end
        end
        ST_SHIFT: begin
          acc <= {acc[VALUE_W-2:0], cur_bit};
          p   <= p_inc;
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            if (is_ns) begin
              state <= ST_NS_CHECK;
            end else begin
              ok    <= 1'b1;
              state <= ST_DONE;
            end
          end
        end
        ST_NS_CHECK: begin
          if (MW'(acc) < m) begin
            ok    <= 1'b1;
            state <= ST_DONE;
          end else if (SW'(p) < limit) begin
            state <= ST_NS_EXTRA;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_NS_EXTRA: begin
          acc   <= {acc[VALUE_W-2:0], cur_bit};
          p     <= p_inc;
          state <= ST_NS_FIX;
        end
        ST_NS_FIX: begin
          acc   <= acc - VALUE_W'(m);
          ok    <= 1'b1;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            value     <= ok ? acc : '0;
            status    <= !ok;
            if (ok) begin
              bit_position <= p;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/msbr_store.sv]
// ----------------------------------------------------------------------------
// msbr_store
// Byte buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module msbr_store
  import msbr_pkg::*;
#(
  parameter int MAX_BYTES = MSBR_MAX_BYTES,
  parameter int AW        = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [MAX_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[dv/msb_bit_reader_with_ns_decode_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msb_bit_reader_with_ns_decode_unit_tb
// Self-checking bench for the MSB-first bit reader with ns decode. A short
// table of directed beats covers the edge cases. Random streams of restart,
// load and read beats follow, mixed with noise. Result beats are checked
// against a shadow copy of the byte buffer and read position, or against the result typed in the table. Idle and stall
// rates change from phase to phase.
// ----------------------------------------------------------------------------
module msb_bit_reader_with_ns_decode_unit_tb;
  import msbr_pkg::*;

  localparam int TOTAL_BEATS = 1950;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } read_res_t;

  typedef struct {
    cmd_t                 op;
    logic [BYTE_W-1:0]    data;
    logic [OPERAND_W-1:0] n;
    bit                   typed;
    logic [VALUE_W-1:0]   value;
    logic                 status;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           cmd = CMD_RESTART;
  logic [BYTE_W-1:0]    byte_in = '0;
  logic [OPERAND_W-1:0] operand_n = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VALUE_W-1:0]   value;
  logic                 status;

  // shadow of the reader state
  logic [BYTE_W-1:0] shadow_bytes [0:MSBR_MAX_BYTES-1];
  int                shadow_pos = 0;
  int                shadow_count = 0;

  read_res_t pending_reads [$];
  int        fail_count = 0;
  int        beats_sent = 0;
  int        send_idle_pct = 0;
  int        sink_stall_pct = 0;
  stim_row_t dir_rows [26];

  msb_bit_reader_with_ns_decode_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .byte_in   (byte_in),
    .operand_n (operand_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status)
  );

  always #5 clk = ~clk;

  function automatic logic shadow_bit(input int p);
    return shadow_bytes[p >> 3][7 - (p & 7)];
  endfunction

  function automatic logic [VALUE_W-1:0] shadow_bits(input int p, input int k);
    logic [VALUE_W-1:0] x;
    x = '0;
    for (int i = 0; i < k; i++) begin
      x = {x[VALUE_W-2:0], shadow_bit(p + i)};
    end
    return x;
  endfunction

  function automatic void predict_beat(input cmd_t op, input logic [BYTE_W-1:0] data,
                                       input logic [OPERAND_W-1:0] n,
                                       output bit has, output read_res_t res);
    int                 lim;
    int                 nn;
    int                 w;
    int                 m;
    int                 p;
    logic [VALUE_W-1:0] v;
    has = 1'b0;
    res = '{value: '0, status: 1'b1};
    lim = shadow_count * 8;
    nn  = int'(n);
    case (op)
      CMD_LOAD: begin
        if (shadow_count < MSBR_MAX_BYTES) begin
          shadow_bytes[shadow_count] = data;
          shadow_count++;
        end
      end
      CMD_RESTART: begin
        shadow_pos   = 0;
        shadow_count = 0;
      end
      CMD_READ_BITS: begin
        has = 1'b1;
        if (nn <= MAX_READ_BITS && shadow_pos <= lim && nn <= lim - shadow_pos) begin
          res.value  = shadow_bits(shadow_pos, nn);
          res.status = 1'b0;
          shadow_pos += nn;
        end
      end
      default: begin
        has = 1'b1;
        if (nn != 0) begin
          w = 0;
          for (int t = nn; t != 0; t = t >> 1) begin
            w++;
          end
          m = (1 << w) - nn;
          if (shadow_pos <= lim && w - 1 <= lim - shadow_pos) begin
            v = shadow_bits(shadow_pos, w - 1);
            p = shadow_pos + w - 1;
            if (int'(v) < m) begin
              res.value  = v;
              res.status = 1'b0;
              shadow_pos = p;
            end else if (p < lim) begin
              res.value  = (v << 1) - VALUE_W'(m) + VALUE_W'(shadow_bit(p));
              res.status = 1'b0;
              shadow_pos = p + 1;
            end
          end
        end
      end
    endcase
  endfunction

  task automatic send_beat(input cmd_t op, input logic [BYTE_W-1:0] data,
                           input logic [OPERAND_W-1:0] n,
                           input bit typed, input read_res_t typed_res);
    bit        has;
    read_res_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    byte_in   <= data;
    operand_n <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat(op, data, n, has, res);
    if (has) begin
      pending_reads.push_back(typed ? typed_res : res);
    end
    beats_sent++;
  endtask

  task automatic send_read(input bit deep);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_beat(CMD_READ_BITS, 8'($urandom),
                (deep && r < 25) ? 16'd32 : 16'($urandom_range(0, 32)), 1'b0, '0);
    end else if (r < 55) begin
      send_beat(CMD_READ_BITS, 8'($urandom), 16'($urandom_range(33, 65535)), 1'b0, '0);
    end else if (r < 88) begin
      send_beat(CMD_READ_NS, 8'($urandom), 16'($urandom_range(1, 300)), 1'b0, '0);
    end else if (r < 96) begin
      send_beat(CMD_READ_NS, 8'($urandom), 16'($urandom_range(0, 65535)), 1'b0, '0);
    end else begin
      send_beat(CMD_READ_NS, 8'($urandom), 16'(1 << $urandom_range(0, 15)), 1'b0, '0);
    end
  endtask

  // one stream: usually a restart, a run of loads, then reads; some streams are pure noise
  task automatic run_stream(input bit force_fill);
    int  n_load;
    int  n_read;
    bit  fill;
    if (!force_fill && $urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 6)) begin
        send_beat(cmd_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), 1'b0, '0);
      end
    end else begin
      fill = force_fill || ($urandom_range(0, 99) < 2);
      if (fill || $urandom_range(0, 99) < 80) begin
        send_beat(CMD_RESTART, 8'($urandom), 16'($urandom), 1'b0, '0);
      end
      // a full buffer ignores the surplus loads
      n_load = fill ? MSBR_MAX_BYTES + $urandom_range(1, 4) : $urandom_range(1, 24);
      n_read = fill ? $urandom_range(60, 90) : $urandom_range(1, 12);
      repeat (n_load) begin
        send_beat(CMD_LOAD, 8'($urandom), 16'($urandom), 1'b0, '0);
      end
      repeat (n_read) begin
        if ($urandom_range(0, 99) < 5) begin
          send_beat(CMD_LOAD, 8'($urandom), 16'($urandom), 1'b0, '0);
        end
        send_read(fill);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    read_res_t want;
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result beat: value %h status %0d", value, status);
        end
      end else begin
        want = pending_reads.pop_front();
        if (value !== want.value || status !== want.status) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result mismatch: expected value %h status %0d, got value %h status %0d",
                     want.value, want.status, value, status);
          end
        end
      end
    end
  end

  initial begin
    int idle_of [4];
    int stall_of [4];
    idle_of  = '{0, 64, 0, 9};
    stall_of = '{0, 0, 64, 9};
    dir_rows = '{
      '{CMD_READ_BITS, 8'h00, 16'd0,     1'b1, 32'h0, 1'b0},
      '{CMD_READ_BITS, 8'h00, 16'd1,     1'b1, 32'h0, 1'b1},
      '{CMD_READ_NS,   8'h00, 16'd0,     1'b1, 32'h0, 1'b1},
      '{CMD_READ_NS,   8'h00, 16'd1,     1'b0, 32'h0, 1'b0},
      '{CMD_READ_BITS, 8'h00, 16'd33,    1'b1, 32'h0, 1'b1},
      '{CMD_READ_BITS, 8'h00, 16'hffff,  1'b1, 32'h0, 1'b1},
      '{CMD_LOAD,      8'hff, 16'h0000,  1'b0, 32'h0, 1'b0},
      '{CMD_LOAD,      8'h00, 16'hffff,  1'b0, 32'h0, 1'b0},
      '{CMD_LOAD,      8'ha5, 16'h0000,  1'b0, 32'h0, 1'b0},
      '{CMD_LOAD,      8'h5a, 16'h0000,  1'b0, 32'h0, 1'b0},
      '{CMD_LOAD,      8'h80, 16'h0000,  1'b0, 32'h0, 1'b0},
      '{CMD_READ_BITS, 8'h00, 16'd32,    1'b0, 32'h0, 1'b0},
      '{CMD_READ_BITS, 8'h00, 16'd9,     1'b1, 32'h0, 1'b1},
      '{CMD_READ_NS,   8'h00, 16'h8000,  1'b1, 32'h0, 1'b1},
      '{CMD_READ_BITS, 8'h00, 16'd8,     1'b0, 32'h0, 1'b0},
      '{CMD_READ_NS,   8'h00, 16'd2,     1'b1, 32'h0, 1'b1},
      '{CMD_RESTART,   8'hff, 16'hffff,  1'b0, 32'h0, 1'b0},
      '{CMD_LOAD,      8'hb6, 16'h0000,  1'b0, 32'h0, 1'b0},
      '{CMD_LOAD,      8'h3c, 16'h0000,  1'b0, 32'h0, 1'b0},
      '{CMD_LOAD,      8'hff, 16'h0000,  1'b0, 32'h0, 1'b0},
      '{CMD_READ_NS,   8'h00, 16'd5,     1'b0, 32'h0, 1'b0},
      '{CMD_READ_NS,   8'h00, 16'd3,     1'b0, 32'h0, 1'b0},
      '{CMD_READ_NS,   8'h00, 16'hffff,  1'b0, 32'h0, 1'b0},
      '{CMD_RESTART,   8'h00, 16'h0000,  1'b0, 32'h0, 1'b0},
      '{CMD_LOAD,      8'hff, 16'h0000,  1'b0, 32'h0, 1'b0},
      '{CMD_READ_BITS, 8'h00, 16'd7,     1'b0, 32'h0, 1'b0}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_of[ph];
      sink_stall_pct = stall_of[ph];
      if (ph == 0) begin
        foreach (dir_rows[i]) begin
          send_beat(dir_rows[i].op, dir_rows[i].data, dir_rows[i].n, dir_rows[i].typed,
                    '{value: dir_rows[i].value, status: dir_rows[i].status});
        end
        // extra ns bit beyond the last loaded byte
        send_beat(CMD_READ_NS, 8'h00, 16'd3, 1'b1, '{value: '0, status: 1'b1});
        run_stream(1'b1);
      end
      while (beats_sent < TOTAL_BEATS * (ph + 1) / 4) begin
        run_stream(1'b0);
      end
      // hold off until the pipe has drained
      in_valid <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clk);
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_reads.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[msb_bit_reader_with_ns_decode_unit.f]
rtl/msbr_pkg.sv
rtl/msbr_store.sv
rtl/msb_bit_reader_with_ns_decode_unit.sv
dv/msb_bit_reader_with_ns_decode_unit_tb.sv
